// ===== sv/frc_pkg.sv =====
// Shared types and constants for the frequency replacement cache.
// Holds the channel payload structs and the chain and update records.
// No dependencies.
package frc_pkg;

  // Index and occupancy widths cover the largest build of 64 ways
  localparam int IDX_W   = 6;
  localparam int USED_W  = 7;
  localparam int COUNT_W = 16;
  localparam int STAMP_W = 32;
  localparam int TOTAL_W = 32;
  localparam int PKEY_W  = 20;
  localparam int CAP_W   = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Item kinds
  localparam logic KIND_ACCESS  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [PKEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [PKEY_W-1:0]  victim_key;
    logic [TOTAL_W-1:0] eviction_total;
  } out_item_t;

  // Scan record handed from cell to cell
  typedef struct packed {
    logic               tok;
    logic               match_f;
    logic [IDX_W-1:0]   match_idx;
    logic               free_f;
    logic [IDX_W-1:0]   free_idx;
    logic               best_f;
    logic [IDX_W-1:0]   best_idx;
    logic [COUNT_W-1:0] best_cnt;
    logic [STAMP_W-1:0] best_stamp;
    logic [USED_W-1:0]  used;
  } chain_t;

  // Update command broadcast to all cells
  typedef struct packed {
    logic               clr;
    logic               en;
    logic               install;
    logic [IDX_W-1:0]   way;
    logic [STAMP_W-1:0] stamp;
  } upd_t;

endpackage

// ===== sv/frequency_replacement_cache.sv =====
// Frequency replacement cache: fully associative store, evicts the most used entry.
// A result is registered once the scan token has passed every cell (a restart skips the scan).
// One item is in flight at a time: input is taken only when idle, after the previous result
// has been registered; a result held in the output register stalls the next.
// Synchronous active-low reset empties the store, zeroes totals, capacity returns to 16.
// Depends on frc_pkg and frc_cell.
module frequency_replacement_cache import frc_pkg::*; #(
  parameter int WAYS     = 16,
  parameter int KEY_BITS = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CAP_W-1:0]    cap_r;
  logic                kind_r;
  logic [KEY_BITS-1:0] key_r;
  logic [STAMP_W-1:0]  acc_r;
  logic [TOTAL_W-1:0]  ev_r;
  chain_t              seed_r, seed_nxt;
  chain_t              fin_r;
  logic [KEY_BITS-1:0] fin_key_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  chain_t              link [WAYS+1];
  logic [KEY_BITS-1:0] link_key [WAYS+1];
  logic [WAYS-1:0]     tok_vec;
  upd_t                upd;

  logic                in_xfer, out_free, finish;
  logic [KEY_BITS+PKEY_W-1:0] in_key_ext;
  logic [KEY_BITS+PKEY_W-1:0] vic_key_ext;
  logic [USED_W-1:0]   cap_eff, cap_ext;
  logic                take_free;
  logic [TOTAL_W-1:0]  ev_inc;
  out_item_t           res;

  // Configuration: capacity register, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(16);
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign finish   = (state_r == S_DEC) && out_free;

  assign in_key_ext  = {{KEY_BITS{1'b0}}, in_data.key};
  assign vic_key_ext = {{PKEY_W{1'b0}}, fin_key_r};

  // Cell chain
  assign link[0]     = seed_r;
  assign link_key[0] = '0;

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    frc_cell #(.KEY_BITS(KEY_BITS), .IDX(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ci        (link[i]),
      .ci_key    (link_key[i]),
      .probe_key (key_r),
      .upd       (upd),
      .co        (link[i+1]),
      .co_key    (link_key[i+1])
    );
    assign tok_vec[i] = link[i+1].tok;
  end

  // Decision on the finished scan record
  always_comb begin
    cap_ext = {2'b00, cap_r};
    if (cap_r == '0) begin
      cap_eff = USED_W'(1);
    end else if (cap_ext > USED_W'(WAYS)) begin
      cap_eff = USED_W'(WAYS);
    end else begin
      cap_eff = cap_ext;
    end
    take_free = (fin_r.used < cap_eff) && fin_r.free_f;
    ev_inc    = (ev_r != TOTAL_MAX) ? ev_r + TOTAL_W'(1) : ev_r;

    upd         = '0;
    upd.stamp   = acc_r;
    res         = '0;
    res.eviction_total = ev_r;
    if (kind_r == KIND_RESTART) begin
      upd.clr            = finish;
      res.eviction_total = '0;
    end else if (fin_r.match_f) begin
      upd.en  = finish;
      upd.way = fin_r.match_idx;
      res.hit = 1'b1;
    end else if (take_free) begin
      upd.en      = finish;
      upd.install = 1'b1;
      upd.way     = fin_r.free_idx;
    end else begin
      upd.en             = finish;
      upd.install        = 1'b1;
      upd.way            = fin_r.best_idx;
      res.evicted        = 1'b1;
      res.victim_key     = vic_key_ext[PKEY_W-1:0];
      res.eviction_total = ev_inc;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_data.kind == KIND_RESTART) ? S_DEC : S_SCAN;
        end
      end
      S_SCAN: begin
        if (link[WAYS].tok) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Scan seed: a fresh record carrying the token for an access
  always_comb begin
    seed_nxt     = '0;
    seed_nxt.tok = in_xfer && (in_data.kind == KIND_ACCESS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      seed_r.tok <= 1'b0;
      acc_r      <= '0;
      ev_r       <= '0;
    end else begin
      state_r <= state_nxt;
      seed_r  <= seed_nxt;
      if (in_xfer && in_data.kind == KIND_ACCESS) begin
        acc_r <= acc_r + STAMP_W'(1);
      end
      if (finish) begin
        if (kind_r == KIND_RESTART) begin
          acc_r <= '0;
          ev_r  <= '0;
        end else begin
          ev_r <= res.eviction_total;
        end
      end
    end
  end

  // Item and scan capture registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r <= in_data.kind;
      key_r  <= in_key_ext[KEY_BITS-1:0];
    end
    if (state_r == S_SCAN && link[WAYS].tok) begin
      fin_r     <= link[WAYS];
      fin_key_r <= link_key[WAYS];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (finish) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // At most one scan token in the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one scan token in the cell chain");

  // The chain only finishes a scan while the sequencer waits for it
  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    link[WAYS].tok |-> (state_r == S_SCAN))
    else $error("scan finished outside the scan state");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.evicted))
    else $error("result flags both hit and eviction");

  // A fresh access transfer starts a scan token in the next cycle
  a_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.kind == KIND_ACCESS) |=> seed_r.tok)
    else $error("access transfer did not launch a scan");
`endif

endmodule

// ===== sv/frc_cell.sv =====
// One way of the cache: holds an entry and folds it into the passing scan record.
// Depends on frc_pkg for the chain and update records.
module frc_cell import frc_pkg::*; #(
  parameter int KEY_BITS = 20,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  chain_t              ci,
  input  logic [KEY_BITS-1:0] ci_key,
  input  logic [KEY_BITS-1:0] probe_key,
  input  upd_t                upd,
  output chain_t              co,
  output logic [KEY_BITS-1:0] co_key
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic                valid_r;
  logic [KEY_BITS-1:0] key_r;
  logic [COUNT_W-1:0]  count_r;
  logic [STAMP_W-1:0]  stamp_r;

  chain_t              co_r, co_nxt;
  logic [KEY_BITS-1:0] co_key_r, co_key_nxt;
  logic                sel;

  // Fold this entry into the record when the token is here
  always_comb begin
    co_nxt     = ci;
    co_key_nxt = ci_key;
    if (ci.tok && valid_r) begin
      co_nxt.used = ci.used + USED_W'(1);
      if (!ci.match_f && key_r == probe_key) begin
        co_nxt.match_f   = 1'b1;
        co_nxt.match_idx = MY_IDX;
      end
      if (!ci.best_f || count_r > ci.best_cnt ||
          (count_r == ci.best_cnt && stamp_r < ci.best_stamp)) begin
        co_nxt.best_f     = 1'b1;
        co_nxt.best_idx   = MY_IDX;
        co_nxt.best_cnt   = count_r;
        co_nxt.best_stamp = stamp_r;
        co_key_nxt        = key_r;
      end
    end else if (ci.tok && !ci.free_f) begin
      co_nxt.free_f   = 1'b1;
      co_nxt.free_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      co_r.tok <= 1'b0;
    end else begin
      co_r <= co_nxt;
    end
    co_key_r <= co_key_nxt;
  end

  assign sel = upd.en && (upd.way == MY_IDX);

  // Entry valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (upd.clr) begin
      valid_r <= 1'b0;
    end else if (sel && upd.install) begin
      valid_r <= 1'b1;
    end
  end

  // Entry payload: install or bump the count
  always_ff @(posedge clk) begin
    if (sel) begin
      if (upd.install) begin
        key_r   <= probe_key;
        count_r <= COUNT_W'(1);
        stamp_r <= upd.stamp;
      end else if (count_r != COUNT_MAX) begin
        count_r <= count_r + COUNT_W'(1);
      end
    end
  end

  assign co     = co_r;
  assign co_key = co_key_r;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for frequency_replacement_cache (most-used eviction, 16 ways).
// Drives items over valid/ready and checks each result against a predictor of the store.
// Depends on frc_pkg and the RTL of frequency_replacement_cache.
module testbench;
  import frc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WAYS          = 16;
  localparam int KEY_W         = 20;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = WAYS + 8;   // scan length plus margin
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 130;
  localparam int MAX_REPORTS   = 10;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  frequency_replacement_cache #(
    .WAYS    (WAYS),
    .KEY_BITS(KEY_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Predicted store contents
  logic               way_valid [WAYS];
  logic [KEY_W-1:0]   way_key   [WAYS];
  logic [COUNT_W-1:0] way_count [WAYS];
  logic [STAMP_W-1:0] way_stamp [WAYS];
  logic [STAMP_W-1:0] access_index;
  logic [TOTAL_W-1:0] eviction_count;
  logic [CAP_W-1:0]   capacity_reg;

  out_item_t expected_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int cycle_count;
  int mismatches;
  int results_checked;
  int items_sent;
  int restarts_sent;
  int hits_seen;
  int evictions_seen;
  int capacity_writes;

  logic [KEY_W-1:0] key_pool[$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Empty the predicted store and its totals
  function automatic void clear_store();
    for (int w = 0; w < WAYS; w++) begin
      way_valid[w] = 1'b0;
      way_key[w]   = '0;
      way_count[w] = '0;
      way_stamp[w] = '0;
    end
    access_index   = '0;
    eviction_count = '0;
  endfunction

  // One access or restart against the predicted store; returns the expected result
  function automatic out_item_t predict_access(input logic kind_i, input logic [KEY_W-1:0] key_i);
    out_item_t res;
    int        cap_eff;
    int        used;
    int        match;
    int        free_w;
    int        best;
    int        slot;
    res    = '0;
    used   = 0;
    match  = -1;
    free_w = -1;
    best   = -1;
    if (kind_i == KIND_RESTART) begin
      clear_store();
      return res;
    end
    cap_eff = capacity_reg;
    if (cap_eff < 1) cap_eff = 1;
    if (cap_eff > WAYS) cap_eff = WAYS;
    access_index = access_index + 1'b1;
    // Tag match, first free way and most-used victim (oldest stamp on a tie)
    for (int w = 0; w < WAYS; w++) begin
      if (way_valid[w]) begin
        used++;
        if (match < 0 && way_key[w] == key_i) match = w;
        if (best < 0 || way_count[w] > way_count[best] ||
            (way_count[w] == way_count[best] && way_stamp[w] < way_stamp[best]))
          best = w;
      end else if (free_w < 0) begin
        free_w = w;
      end
    end
    if (match >= 0) begin
      res.hit = 1'b1;
      if (way_count[match] != COUNT_MAX) way_count[match] = way_count[match] + 1'b1;
    end else begin
      if (used < cap_eff && free_w >= 0) begin
        slot = free_w;
      end else begin
        slot           = best;
        res.evicted    = 1'b1;
        res.victim_key = way_key[slot];
        if (eviction_count != TOTAL_MAX) eviction_count = eviction_count + 1'b1;
      end
      way_valid[slot] = 1'b1;
      way_key[slot]   = key_i;
      way_count[slot] = COUNT_W'(1);
      way_stamp[slot] = access_index;
    end
    res.eviction_total = eviction_count;
    return res;
  endfunction

  // Offer one item, with a random gap first; predict on transfer
  task automatic send_item(input logic kind_i, input logic [KEY_W-1:0] key_i);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{kind: kind_i, key: key_i};
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_access(kind_i, key_i));
    items_sent++;
    if (kind_i == KIND_RESTART) restarts_sent++;
  endtask

  task automatic send_key(input logic [KEY_W-1:0] key_i);
    send_item(KIND_ACCESS, key_i);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Capacity write, only with the block idle
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    capacity_reg = value;
    capacity_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Skewed pick from the hot key set so counts spread out; now and then a fresh key
  function automatic logic [KEY_W-1:0] pick_key();
    int a;
    int b;
    if ($urandom_range(99) < 8) return KEY_W'($urandom);
    a = $urandom_range(key_pool.size() - 1);
    b = $urandom_range(key_pool.size() - 1);
    return key_pool[(a < b) ? a : b];
  endfunction

  // Directed: victim choice, tie on stamp, restart, capacity extremes and lowering
  task automatic test_directed();
    write_capacity(5'd2);
    send_key(20'h00000);
    send_key(20'hFFFFF);
    send_key(20'h00000);    // hit, count 2
    send_key(20'hA5A5A);    // full: most used entry goes
    send_key(20'hFFFFF);    // hit
    send_key(20'h5A5A5);    // evicts 0xFFFFF
    send_key(20'hA5A5A);    // hit, stamp must stay
    send_key(20'h5A5A5);    // hit, equal counts now
    send_key(20'h0F0F0);    // tie broken by older stamp
    send_item(KIND_RESTART, 20'hFFFFF);
    write_capacity(5'd0);   // acts as one way
    send_key(20'h12345);
    send_key(20'h54321);
    send_key(20'h54321);
    write_capacity(5'd31);  // above the way count
    write_capacity(5'd4);
    send_item(KIND_RESTART, 20'h00000);
    for (int i = 0; i < 4; i++) send_key(KEY_W'(20'h30000 + i));
    // Lowered below occupancy: misses replace, nothing is dropped
    write_capacity(5'd1);
    send_key(20'h40000);
    send_key(20'h40001);
    send_key(20'h30003);
  endtask

  // Random phases across capacities under one idling pattern
  task automatic test_random(input int send_pct, input int recv_pct,
                             input logic [CAP_W-1:0] caps[4]);
    int cap_eff;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      cap_eff = (caps[p] == 0) ? 1 : (caps[p] > WAYS) ? WAYS : caps[p];
      key_pool.delete();
      repeat (cap_eff + $urandom_range(1, 6)) key_pool.push_back(KEY_W'($urandom));
      if ($urandom_range(1)) send_item(KIND_RESTART, KEY_W'($urandom));
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(99) < 2) send_item(KIND_RESTART, KEY_W'($urandom));
        else send_key(pick_key());
      end
    end
  endtask

  // Long receiver hold-off while items keep coming, then a full drain and a further run of items
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(5'd6);
    key_pool.delete();
    repeat (9) key_pool.push_back(KEY_W'($urandom));
    hold_cycles = 300;
    repeat (40) send_key(pick_key());
    wait_idle();
    repeat (30) send_key(pick_key());
  endtask

  // Receiver readiness, with an optional counted hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result check on every transfer
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result at cycle %0d: %p", cycle_count, out_data);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_data.hit) hits_seen++;
        if (out_data.evicted) evictions_seen++;
        if (out_data.hit !== want.hit || out_data.evicted !== want.evicted ||
            out_data.victim_key !== want.victim_key ||
            out_data.eviction_total !== want.eviction_total) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch at cycle %0d: expected hit %0b evicted %0b victim %05h ",
                      "total %0d, got hit %0b evicted %0b victim %05h total %0d"},
                     cycle_count, want.hit, want.evicted, want.victim_key,
                     want.eviction_total, out_data.hit, out_data.evicted,
                     out_data.victim_key, out_data.eviction_total);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    send_idle_pct   = 35;
    recv_idle_pct   = 82;
    hold_cycles     = 0;
    cycle_count     = 0;
    mismatches      = 0;
    results_checked = 0;
    items_sent      = 0;
    restarts_sent   = 0;
    hits_seen       = 0;
    evictions_seen  = 0;
    capacity_writes = 0;
    clear_store();
    capacity_reg = 5'd16;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(35, 82, '{5'd16, 5'd1, 5'd31, 5'd3});
    test_random(82, 35, '{5'd17, 5'd8, 5'd0, 5'd12});
    test_random(0, 0, '{5'd2, 5'd24, 5'd5, 5'd16});
    test_backpressure();
    wait_idle();

    $display("Run covered %0d items (%0d restarts) over %0d capacity writes in %0d cycles",
             items_sent, restarts_sent, capacity_writes, cycle_count);
    $display("Checked %0d results: %0d hits, %0d evictions, %0d mismatches",
             results_checked, hits_seen, evictions_seen, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
